### sv/ssp_pkg.sv
// shared types and constants for the sphere pushout pipeline
// no dependencies
package ssp_pkg;

	localparam int COORD_W = 24;
	localparam int RAD_W   = 23;
	localparam int MAG_W   = 24;
	localparam int SQ_W    = 50;
	localparam int ROOT_W  = 25;
	localparam int H_W     = 26;
	localparam int HMAG_W  = 25;
	localparam int PROD_W  = 49;
	localparam int NUM_W   = 50;
	localparam int DEN_W   = 26;
	localparam int Q_W     = 24;
	localparam int LATENCY = 3 + ROOT_W + 3 + Q_W + 1;

	localparam logic signed [COORD_W-1:0] PUSH_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic signed [COORD_W-1:0] PUSH_MIN = {1'b1, {(COORD_W-1){1'b0}}};
	localparam logic [Q_W-1:0] Q_POS_MAX = {1'b0, {(Q_W-1){1'b1}}};
	localparam logic [Q_W-1:0] Q_NEG_MAX = {1'b1, {(Q_W-1){1'b0}}};

	typedef struct packed {
		logic signed [COORD_W-1:0] center_a_x;
		logic signed [COORD_W-1:0] center_a_y;
		logic signed [COORD_W-1:0] center_a_z;
		logic signed [COORD_W-1:0] center_b_x;
		logic signed [COORD_W-1:0] center_b_y;
		logic signed [COORD_W-1:0] center_b_z;
		logic [RAD_W-1:0]          radius_a;
		logic [RAD_W-1:0]          radius_b;
		logic                      static_a;
		logic                      static_b;
	} ssp_in_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] push_x;
		logic signed [COORD_W-1:0] push_y;
		logic signed [COORD_W-1:0] push_z;
		logic                      apply_move;
		logic                      degenerate;
		logic                      saturated;
	} ssp_out_t;

	// side data carried alongside the square root
	typedef struct packed {
		logic [2:0][MAG_W-1:0] dmag;
		logic [2:0]            dneg;
		logic [MAG_W-1:0]      rsum;
		logic                  move;
		logic                  degen;
	} ssp_sq_tag_t;

	// side data carried alongside the divider
	typedef struct packed {
		logic [2:0] neg;
		logic       move;
		logic       degen;
	} ssp_div_tag_t;

endpackage

### sv/sphere_sphere_pushout.sv
// top level of the sphere pushout engine
// depends on ssp_pkg, ssp_sqrt and ssp_div
//
// One sphere pair is taken in every clock cycle; busy never rises. Each item
// gives exactly one result. done is high for one cycle, together with the result
// in the output register. The 56 register stages are: difference, squares and
// sum of squares, 25 square-root stages (one root bit each), overlap, product and
// numerator, 24 divider stages (one quotient bit each) and the output register.
// The receiver cannot stall, so results must be taken as they appear.
module sphere_sphere_pushout (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  ssp_pkg::ssp_in_t  args,
	output logic              busy,
	output logic              done,
	output ssp_pkg::ssp_out_t result
);
	import ssp_pkg::*;

	// difference stage
	logic                      v_s1;
	logic [2:0][MAG_W-1:0]     dmag_s1;
	logic [2:0]                dneg_s1;
	logic [MAG_W-1:0]          rsum_s1;
	logic                      move_s1;
	logic [2:0][COORD_W:0]     dfull;
	logic [2:0][COORD_W:0]     dinv;

	always_comb begin
		dfull[0] = {args.center_b_x[COORD_W-1], args.center_b_x}
			- {args.center_a_x[COORD_W-1], args.center_a_x};
		dfull[1] = {args.center_b_y[COORD_W-1], args.center_b_y}
			- {args.center_a_y[COORD_W-1], args.center_a_y};
		dfull[2] = {args.center_b_z[COORD_W-1], args.center_b_z}
			- {args.center_a_z[COORD_W-1], args.center_a_z};
		for (int i = 0; i < 3; i++) begin
			dinv[i] = -dfull[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			dneg_s1[i] <= dfull[i][COORD_W];
			dmag_s1[i] <= dfull[i][COORD_W] ? dinv[i][MAG_W-1:0] : dfull[i][MAG_W-1:0];
		end
		rsum_s1 <= {1'b0, args.radius_a} + {1'b0, args.radius_b};
		move_s1 <= !(args.static_a && args.static_b);
	end

	// squares
	logic                      v_s2;
	logic [2:0][2*MAG_W-1:0]   sq_s2;
	logic [2:0][MAG_W-1:0]     dmag_s2;
	logic [2:0]                dneg_s2;
	logic [MAG_W-1:0]          rsum_s2;
	logic                      move_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sq_s2[i] <= dmag_s1[i] * dmag_s1[i];
		end
		dmag_s2 <= dmag_s1;
		dneg_s2 <= dneg_s1;
		rsum_s2 <= rsum_s1;
		move_s2 <= move_s1;
	end

	// sum of squares
	logic                      v_s3;
	logic [SQ_W-1:0]           sumsq_s3;
	ssp_sq_tag_t               sqtag_s3;
	logic [SQ_W-1:0]           sumsq;

	assign sumsq = SQ_W'(sq_s2[0]) + SQ_W'(sq_s2[1]) + SQ_W'(sq_s2[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		sumsq_s3       <= sumsq;
		sqtag_s3.dmag  <= dmag_s2;
		sqtag_s3.dneg  <= dneg_s2;
		sqtag_s3.rsum  <= rsum_s2;
		sqtag_s3.move  <= move_s2;
		sqtag_s3.degen <= (sumsq == '0);
	end

	// length
	logic              sq_v;
	logic [ROOT_W-1:0] sq_root;
	ssp_sq_tag_t       sq_tag;

	ssp_sqrt #(
		.TAG_W ($bits(ssp_sq_tag_t))
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.in_rad    (sumsq_s3),
		.in_tag    (sqtag_s3),
		.out_valid (sq_v),
		.out_root  (sq_root),
		.out_tag   (sq_tag)
	);

	// overlap
	logic                  v_s4;
	logic [HMAG_W-1:0]     hmag_s4;
	logic                  hneg_s4;
	logic [ROOT_W-1:0]     len_s4;
	ssp_sq_tag_t           tag_s4;
	logic [H_W-1:0]        h;
	logic [H_W-1:0]        hinv;

	assign h    = {2'b00, sq_tag.rsum} - {1'b0, sq_root};
	assign hinv = -h;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= sq_v;
		end
	end

	always_ff @(posedge clk) begin
		hneg_s4 <= h[H_W-1];
		hmag_s4 <= h[H_W-1] ? hinv[HMAG_W-1:0] : h[HMAG_W-1:0];
		len_s4  <= sq_root;
		tag_s4  <= sq_tag;
	end

	// products
	logic                   v_s5;
	logic [2:0][PROD_W-1:0] prod_s5;
	logic [ROOT_W-1:0]      len_s5;
	ssp_div_tag_t           dtag_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			prod_s5[i]     <= tag_s4.dmag[i] * hmag_s4;
			dtag_s5.neg[i] <= tag_s4.dneg[i] ^ hneg_s4;
		end
		len_s5        <= len_s4;
		dtag_s5.move  <= tag_s4.move;
		dtag_s5.degen <= tag_s4.degen;
	end

	// numerator with rounding term, divisor 2L
	logic                  v_s6;
	logic [2:0][NUM_W-1:0] num_s6;
	logic [DEN_W-1:0]      den_s6;
	ssp_div_tag_t          dtag_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			num_s6[i] <= {1'b0, prod_s5[i]} + NUM_W'(len_s5);
		end
		den_s6  <= {len_s5, 1'b0};
		dtag_s6 <= dtag_s5;
	end

	logic                dv_v;
	logic [2:0][Q_W-1:0] dv_quo;
	logic [2:0]          dv_ovf;
	ssp_div_tag_t        dv_tag;

	ssp_div #(
		.TAG_W ($bits(ssp_div_tag_t))
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s6),
		.in_num    (num_s6),
		.in_den    (den_s6),
		.in_tag    (dtag_s6),
		.out_valid (dv_v),
		.out_quo   (dv_quo),
		.out_ovf   (dv_ovf),
		.out_tag   (dv_tag)
	);

	// sign, clamp and special cases
	logic [2:0][COORD_W-1:0] push;
	logic [2:0]              clamp;
	logic                    zero_out;
	logic [COORD_W-1:0]      qneg;
	ssp_out_t                res;

	always_comb begin
		zero_out = !dv_tag.move || dv_tag.degen;
		for (int i = 0; i < 3; i++) begin
			qneg     = -dv_quo[i];
			clamp[i] = 1'b0;
			if (dv_ovf[i]) begin
				push[i]  = dv_tag.neg[i] ? PUSH_MIN : PUSH_MAX;
				clamp[i] = 1'b1;
			end else if (dv_tag.neg[i] && dv_quo[i] != '0) begin
				if (dv_quo[i] > Q_NEG_MAX) begin
					push[i]  = PUSH_MIN;
					clamp[i] = 1'b1;
				end else begin
					push[i] = qneg;
				end
			end else if (dv_quo[i] > Q_POS_MAX) begin
				push[i]  = PUSH_MAX;
				clamp[i] = 1'b1;
			end else begin
				push[i] = dv_quo[i];
			end
			if (zero_out) begin
				push[i]  = '0;
				clamp[i] = 1'b0;
			end
		end
		res.push_x     = push[0];
		res.push_y     = push[1];
		res.push_z     = push[2];
		res.apply_move = dv_tag.move;
		res.degenerate = dv_tag.move && dv_tag.degen;
		res.saturated  = |clamp;
	end

	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_v;
		end
	end

	always_ff @(posedge clk) begin
		result <= res;
	end

	assign done = done_q;
	assign busy = 1'b0;

endmodule

### sv/ssp_sqrt.sv
// pipelined integer square root, one result bit per stage
// depends on ssp_pkg
module ssp_sqrt #(
	parameter int TAG_W = 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [ssp_pkg::SQ_W-1:0]  in_rad,
	input  logic [TAG_W-1:0]          in_tag,
	output logic                      out_valid,
	output logic [ssp_pkg::ROOT_W-1:0] out_root,
	output logic [TAG_W-1:0]          out_tag
);
	import ssp_pkg::*;

	localparam int REM_W = ROOT_W + 2;

	logic [ROOT_W-1:0]             v_s;
	logic [ROOT_W-1:0][REM_W-1:0]  rem_s;
	logic [ROOT_W-1:0][ROOT_W-1:0] root_s;
	logic [ROOT_W-1:0][SQ_W-1:0]   rad_s;
	logic [ROOT_W-1:0][TAG_W-1:0]  tag_s;

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		logic              p_v;
		logic [REM_W-1:0]  p_rem;
		logic [ROOT_W-1:0] p_root;
		logic [SQ_W-1:0]   p_rad;
		logic [TAG_W-1:0]  p_tag;
		logic [REM_W-1:0]  cur;
		logic [REM_W-1:0]  trial;
		logic              take;

		if (k == 0) begin : g_first
			assign p_v    = in_valid;
			assign p_rem  = '0;
			assign p_root = '0;
			assign p_rad  = in_rad;
			assign p_tag  = in_tag;
		end else begin : g_next
			assign p_v    = v_s[k-1];
			assign p_rem  = rem_s[k-1];
			assign p_root = root_s[k-1];
			assign p_rad  = rad_s[k-1];
			assign p_tag  = tag_s[k-1];
		end

		assign cur   = {p_rem[REM_W-3:0], p_rad[SQ_W-1:SQ_W-2]};
		assign trial = {p_root, 2'b01};
		assign take  = (cur >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else begin
				v_s[k] <= p_v;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k]  <= take ? (cur - trial) : cur;
			root_s[k] <= {p_root[ROOT_W-2:0], take};
			rad_s[k]  <= {p_rad[SQ_W-3:0], 2'b00};
			tag_s[k]  <= p_tag;
		end
	end

	assign out_valid = v_s[ROOT_W-1];
	assign out_root  = root_s[ROOT_W-1];
	assign out_tag   = tag_s[ROOT_W-1];

endmodule

### sv/ssp_div.sv
// pipelined restoring divider, three lanes sharing one divisor
// one quotient bit per stage; flags quotients that do not fit; depends on ssp_pkg
module ssp_div #(
	parameter int TAG_W = 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic [2:0][ssp_pkg::NUM_W-1:0]   in_num,
	input  logic [ssp_pkg::DEN_W-1:0]        in_den,
	input  logic [TAG_W-1:0]                 in_tag,
	output logic                             out_valid,
	output logic [2:0][ssp_pkg::Q_W-1:0]     out_quo,
	output logic [2:0]                       out_ovf,
	output logic [TAG_W-1:0]                 out_tag
);
	import ssp_pkg::*;

	logic [Q_W-1:0]                 v_s;
	logic [Q_W-1:0][2:0][DEN_W-1:0] rem_s;
	logic [Q_W-1:0][2:0][Q_W-1:0]   lo_s;
	logic [Q_W-1:0][2:0][Q_W-1:0]   quo_s;
	logic [Q_W-1:0][2:0]            ovf_s;
	logic [Q_W-1:0][DEN_W-1:0]      den_s;
	logic [Q_W-1:0][TAG_W-1:0]      tag_s;

	for (genvar k = 0; k < Q_W; k++) begin : g_stage
		logic                  p_v;
		logic [2:0][DEN_W-1:0] p_rem;
		logic [2:0][Q_W-1:0]   p_lo;
		logic [2:0][Q_W-1:0]   p_quo;
		logic [2:0]            p_ovf;
		logic [DEN_W-1:0]      p_den;
		logic [TAG_W-1:0]      p_tag;
		logic [2:0][DEN_W:0]   cur;
		logic [2:0]            take;

		if (k == 0) begin : g_first
			always_comb begin
				for (int i = 0; i < 3; i++) begin
					p_rem[i] = in_num[i][NUM_W-1:Q_W];
					p_lo[i]  = in_num[i][Q_W-1:0];
					p_ovf[i] = (in_num[i][NUM_W-1:Q_W] >= in_den);
				end
			end
			assign p_v   = in_valid;
			assign p_quo = '0;
			assign p_den = in_den;
			assign p_tag = in_tag;
		end else begin : g_next
			assign p_v   = v_s[k-1];
			assign p_rem = rem_s[k-1];
			assign p_lo  = lo_s[k-1];
			assign p_quo = quo_s[k-1];
			assign p_ovf = ovf_s[k-1];
			assign p_den = den_s[k-1];
			assign p_tag = tag_s[k-1];
		end

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				cur[i]  = {p_rem[i], p_lo[i][Q_W-1]};
				take[i] = (cur[i] >= {1'b0, p_den});
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else begin
				v_s[k] <= p_v;
			end
		end

		always_ff @(posedge clk) begin
			for (int i = 0; i < 3; i++) begin
				rem_s[k][i] <= take[i] ? DEN_W'(cur[i] - {1'b0, p_den}) : cur[i][DEN_W-1:0];
				lo_s[k][i]  <= {p_lo[i][Q_W-2:0], 1'b0};
				quo_s[k][i] <= {p_quo[i][Q_W-2:0], take[i]};
			end
			ovf_s[k] <= p_ovf;
			den_s[k] <= p_den;
			tag_s[k] <= p_tag;
		end
	end

	assign out_valid = v_s[Q_W-1];
	assign out_quo   = quo_s[Q_W-1];
	assign out_ovf   = ovf_s[Q_W-1];
	assign out_tag   = tag_s[Q_W-1];

endmodule

### sv/ssp_chk.sv
// port-level checks for the sphere pushout engine, bound to the top level
// depends on ssp_pkg
module ssp_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input ssp_pkg::ssp_out_t result
);
	import ssp_pkg::*;

	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without item");

	a_static: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.apply_move |-> result.push_x == '0 && result.push_y == '0
			&& result.push_z == '0 && !result.degenerate && !result.saturated)
		else $error("static pair moved");

	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.degenerate |-> result.push_x == '0 && result.push_y == '0
			&& result.push_z == '0 && !result.saturated)
		else $error("degenerate push not zero");

	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.saturated |-> result.push_x == PUSH_MAX || result.push_x == PUSH_MIN
			|| result.push_y == PUSH_MAX || result.push_y == PUSH_MIN
			|| result.push_z == PUSH_MAX || result.push_z == PUSH_MIN)
		else $error("saturated with no clamped component");

endmodule

bind sphere_sphere_pushout ssp_chk u_ssp_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
